>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BLI_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked on the following edge.
`define BLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked a fixed number of edges later.
`define BLI_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bli_pkg.sv
package bli_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COUNT_W        = 5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_UNSORTED = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [3:0]         point_index;
    logic [15:0]        point_x;
    logic signed [15:0] point_y;
    logic [15:0]        query_x;
  } in_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [1:0]         status;
  } out_t;

  // Word handed from cell to cell during a search.
  typedef struct packed {
    logic               valid;
    logic [15:0]        qx;
    logic [15:0]        prev_x;
    logic signed [15:0] prev_y;
    logic               lo;
    logic               hi;
    logic signed [15:0] res_y;
    logic               found;
    logic [15:0]        x0;
    logic signed [15:0] y0;
    logic [15:0]        x1;
    logic signed [15:0] y1;
  } carry_t;

endpackage

>>> hw/rtl/bli_cell.sv
module bli_cell #(
  parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF,
  parameter int INDEX      = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               we,
  input  logic [15:0]                        wr_x,
  input  logic signed [15:0]                 wr_y,
  input  logic [$clog2(MAX_POINTS+1)-1:0]    count,
  input  bli_pkg::carry_t                    carry_in,
  output bli_pkg::carry_t                    carry_out
);
  import bli_pkg::*;

  localparam int NW = $clog2(MAX_POINTS + 1);

  logic [15:0]        pos;
  logic signed [15:0] val;
  logic               active;
  logic               last;
  logic               vld;
  carry_t             nxt;
  carry_t             pay;

  always_ff @(posedge clk) begin
    if (we) begin
      pos <= wr_x;
      val <= wr_y;
    end
  end

  assign active = NW'(INDEX) < count;
  assign last   = NW'(INDEX + 1) == count;

  always_comb begin
    nxt = carry_in;
    if (active) begin
      nxt.prev_x = pos;
      nxt.prev_y = val;
    end
    if (active && INDEX == 0 && carry_in.qx <= pos) begin
      nxt.lo    = 1'b1;
      nxt.res_y = val;
    end
    // later hits overwrite earlier ones: last containing segment wins
    if (active && INDEX != 0 && carry_in.prev_x <= carry_in.qx && pos >= carry_in.qx) begin
      nxt.found = 1'b1;
      nxt.x0    = carry_in.prev_x;
      nxt.y0    = carry_in.prev_y;
      nxt.x1    = pos;
      nxt.y1    = val;
    end
    if (last && !nxt.lo && carry_in.qx >= pos) begin
      nxt.hi    = 1'b1;
      nxt.res_y = val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= carry_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    pay <= nxt;
  end

  always_comb begin
    carry_out       = pay;
    carry_out.valid = vld;
  end

endmodule

>>> hw/rtl/bli_divider.sv
module bli_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  import bli_pkg::*;

  localparam int STEPS = 16;
  localparam int CW    = $clog2(STEPS);

  logic [15:0]   rem;
  logic [15:0]   acc;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [16:0]   trial;
  logic [16:0]   diff;
  logic          ge;
  logic [15:0]   rem_next;

  // upper half of the dividend is known to be below the divisor,
  // so sixteen quotient bits suffice
  assign trial    = {rem, acc[15]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_next = ge ? diff[15:0] : trial[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == CW'(STEPS - 1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[31:16];
      acc <= dividend[15:0];
    end else if (busy) begin
      rem <= rem_next;
      acc <= {acc[14:0], ge};
    end
  end

  assign quotient = acc;

endmodule

>>> hw/rtl/breakpoint_linear_interpolator_unit.sv
// Breakpoint table with piecewise-linear lookup.
// Input channel (in_valid / in_stall / in_word): a word with mode write stores one
// breakpoint in its slot and is acknowledged with value 0, status ok; a word with
// mode query returns the interpolated value at query_x. Output channel
// (out_valid / out_stall / out_word) carries one word per input word, in order.
// Config channel (cfg_valid / cfg_ready / cfg_data) sets point_count; write it
// only while no word is in flight. cfg_ready is always high.
// One word is processed at a time: in_stall is high from acceptance until the
// result has been loaded into the output register.
// A write or an empty-table query goes straight to S_FIN; a clamped, zero-width
// or unsorted query goes after the search, an interpolated one after the search,
// a multiply and the divide. The search walks a row of MAX_POINTS cells, one cell
// a cycle; the quotient comes from a 16-step restoring divider.
// The output register holds its word while out_stall is high; the next input
// word may be accepted meanwhile, its result waits until the register frees.
// Synchronous reset clears point_count and the control; breakpoints are
// undefined until written.
module breakpoint_linear_interpolator_unit #(
  parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bli_pkg::in_t                   in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bli_pkg::out_t                  out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bli_pkg::COUNT_W-1:0]    cfg_data
);
  import bli_pkg::*;

  localparam int NW = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [COUNT_W-1:0] point_count;
  logic [NW-1:0]      n;
  logic               in_acc;
  logic               wr_acc;
  logic               out_load;
  carry_t             chain [MAX_POINTS+1];
  carry_t             tail;
  logic               tail_direct;
  logic signed [16:0] dy;
  logic [16:0]        dy_abs;
  out_t               res;
  logic signed [15:0] y0;
  logic               neg;
  logic [15:0]        dy_mag;
  logic [15:0]        dx;
  logic [15:0]        w;
  logic [31:0]        prod;
  logic               div_done;
  logic [15:0]        quot;
  logic [16:0]        q_signed;
  logic [16:0]        sum;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign wr_acc    = in_acc && in_word.mode == MODE_WRITE;
  assign out_load  = state == S_FIN && (!out_valid || !out_stall);

  always_comb begin
    if (32'(point_count) > 32'(MAX_POINTS)) begin
      n = NW'(MAX_POINTS);
    end else begin
      n = NW'(point_count);
    end
  end

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = in_acc && in_word.mode == MODE_QUERY && n != '0;
    chain[0].qx    = in_word.query_x;
  end

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    bli_cell #(
      .MAX_POINTS (MAX_POINTS),
      .INDEX      (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .we        (wr_acc && 32'(in_word.point_index) == 32'(g)),
      .wr_x      (in_word.point_x),
      .wr_y      (in_word.point_y),
      .count     (n),
      .carry_in  (chain[g]),
      .carry_out (chain[g+1])
    );
  end

  assign tail        = chain[MAX_POINTS];
  assign tail_direct = tail.lo || tail.hi || !tail.found || tail.x1 == tail.x0;
  assign dy          = $signed({tail.y1[15], tail.y1}) - $signed({tail.y0[15], tail.y0});
  assign dy_abs      = dy[16] ? 17'(-dy) : 17'(dy);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (in_word.mode == MODE_QUERY && n != '0) ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          state_next = tail_direct ? S_FIN : S_MUL;
        end
      end
      S_MUL:   state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      point_count <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        point_count <= cfg_data;
      end
    end
  end

  assign q_signed = neg ? 17'(-{1'b0, quot}) : {1'b0, quot};
  assign sum      = {y0[15], y0} + q_signed;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      res.value  <= '0;
      res.status <= (in_word.mode == MODE_QUERY) ? ST_EMPTY : ST_OK;
    end
    if (state == S_SCAN && tail.valid) begin
      if (tail.lo || tail.hi) begin
        res.value  <= tail.res_y;
        res.status <= ST_OK;
      end else if (!tail.found) begin
        res.value  <= '0;
        res.status <= ST_UNSORTED;
      end else begin
        // zero-width segment takes the left y
        res.value  <= tail.y0;
        res.status <= ST_OK;
      end
      y0     <= tail.y0;
      neg    <= dy[16];
      dy_mag <= dy_abs[15:0];
      dx     <= tail.qx - tail.x0;
      w      <= tail.x1 - tail.x0;
    end
    if (state == S_MUL) begin
      prod <= dy_mag * dx;
    end
    if (state == S_DIV && div_done) begin
      res.value <= sum[15:0];
    end
    if (out_load) begin
      out_word <= res;
    end
  end

  bli_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVGO),
    .dividend (prod),
    .divisor  (w),
    .done     (div_done),
    .quotient (quot)
  );

endmodule

>>> hw/rtl/bli_checker.sv
`include "assert_macros.svh"

module bli_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input bli_pkg::in_t                in_word,
  input logic                        out_valid,
  input logic                        out_stall,
  input bli_pkg::out_t               out_word,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [bli_pkg::COUNT_W-1:0] cfg_data
);
  import bli_pkg::*;

  // one word in flight: acceptance closes the input side
  `BLI_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "input not stalled after acceptance")

  `BLI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")

  // error statuses carry a zero value
  `BLI_ASSERT_IMPL(a_err_zero, clk, rst, out_valid && out_word.status != ST_OK, out_word.value == '0, "error word with non-zero value")

  // a write accepted while the output register is empty comes back as ok with value 0
  `BLI_ASSERT_DELAY(a_write_ack, clk, rst, in_valid && !in_stall && in_word.mode == MODE_WRITE && !out_valid, 2, out_valid && out_word.status == ST_OK && out_word.value == '0, "write not acknowledged")

  `BLI_ASSERT_IMPL(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "config write refused")

endmodule

bind breakpoint_linear_interpolator_unit bli_checker u_chk (.*);
